// File: rtl/vmia_pkg.sv
// shared types, opcodes and helper functions for the vm integer alu
// no dependencies
`default_nettype none

package vmia_pkg;

    localparam int unsigned ActionWidth  = 5;
    localparam int unsigned DataWidth    = 64;
    localparam int unsigned WordWidth    = 32;
    localparam int unsigned ImmWidth     = 8;
    localparam int unsigned DestWidth    = 2;

    typedef enum logic [ActionWidth-1:0] {
        ACT_NEG32    = 5'd0,
        ACT_NEG64    = 5'd1,
        ACT_NOT      = 5'd2,
        ACT_ADD32    = 5'd3,
        ACT_SUB32    = 5'd4,
        ACT_MUL32    = 5'd5,
        ACT_ADD32I   = 5'd6,
        ACT_SUB32I   = 5'd7,
        ACT_MUL32I   = 5'd8,
        ACT_ADD64    = 5'd9,
        ACT_SUB64    = 5'd10,
        ACT_MUL64    = 5'd11,
        ACT_EQ32     = 5'd12,
        ACT_LT32     = 5'd13,
        ACT_EQ32I    = 5'd14,
        ACT_LT32I    = 5'd15,
        ACT_EQ64     = 5'd16,
        ACT_LT64     = 5'd17,
        ACT_SEXT32   = 5'd18,
        ACT_SEXT8    = 5'd19,
        ACT_TRUNC8   = 5'd20,
        ACT_TRUNC16  = 5'd21,
        ACT_TRUNC32  = 5'd22
    } t_action;

    typedef enum logic [DestWidth-1:0] {
        DW_32  = 2'd0,
        DW_16  = 2'd1,
        DW_8   = 2'd2,
        DW_ALT = 2'd3
    } t_dest;

    // control carried alongside the partial products
    typedef struct packed {
        logic                 is_mul64;
        logic                 is_mul32;
        logic [DestWidth-1:0] dest_width;
    } t_mul_ctl;

    // mask a 32-bit value to the destination width, zero-extended to 64
    function automatic logic [DataWidth-1:0] width_mask(
        input logic [WordWidth-1:0] v,
        input logic [DestWidth-1:0] dw
    );
        logic [WordWidth-1:0] x;
        x = v;
        case (t_dest'(dw))
            DW_16:   x = {16'h0000, v[15:0]};
            DW_8:    x = {24'h000000, v[7:0]};
            default: x = v;
        endcase
        return {32'h0000_0000, x};
    endfunction

    function automatic logic [WordWidth-1:0] sext_imm(input logic [ImmWidth-1:0] imm);
        return {{(WordWidth-ImmWidth){imm[ImmWidth-1]}}, imm};
    endfunction

endpackage

`default_nettype wire

// File: rtl/vm_integer_alu_unit.sv
// top level of the vm integer alu: input register, product stage, result register
// depends on vmia_pkg and vmia_logic
`default_nettype none

// Integer execution unit for a bytecode machine. One beat in carries an opcode,
// two 64-bit operands, a signed 8-bit immediate and a destination width code;
// one beat out carries the 64-bit result. The unit takes a new beat every cycle
// while o_stall is low; a beat accepted into the input register passes through the
// product stage and the result register before it shows on o_valid. Three register stages: an input
// register, a stage that holds three 32x32 partial products (together with the
// already finished result of every non-multiply operation), and a result
// register where the partial products are summed for the 64-bit multiply or
// masked for the 32-bit multiply. 32-bit operations wrap, are masked to the
// destination width and zero-extended; 64-bit operations wrap. Compares and not
// give 0 or 1, unused opcodes give 0. Each stage advances when the stage after
// it is empty or moving, so bubbles are squeezed out and o_stall only rises
// when all three stages hold beats and i_stall is high.

module vm_integer_alu_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input channel
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [4:0]  i_action,
    input  wire logic [63:0] i_operand_a,
    input  wire logic [63:0] i_operand_b,
    input  wire logic [7:0]  i_immediate,
    input  wire logic [1:0]  i_dest_width,
    // result channel
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic      [63:0] o_result
);

    // stage valids and advance enables
    logic r_v1, r_v2, r_v3;
    logic adv1, adv2, adv3;

    // stage 1: registered input beat
    logic [4:0]  r_action;
    logic [63:0] r_a;
    logic [63:0] r_b;
    logic [7:0]  r_imm;
    logic [1:0]  r_dw;

    // stage 2: partial products and finished non-multiply result
    logic [63:0]        r_p_ll;
    logic [31:0]        r_p_lh;
    logic [31:0]        r_p_hl;
    logic [63:0]        r_other;
    vmia_pkg::t_mul_ctl r_ctl;

    // stage 3: result register
    logic [63:0] r_result;

    logic [63:0]        n_other;
    logic [31:0]        mul_b_lo;
    logic [63:0]        n_p_ll;
    logic [31:0]        n_p_lh;
    logic [31:0]        n_p_hl;
    vmia_pkg::t_mul_ctl n_ctl;
    logic [31:0]        cross_sum;
    logic [63:0]        n_result;

    assign adv3    = !r_v3 || !i_stall;
    assign adv2    = !r_v2 || adv3;
    assign adv1    = !r_v1 || adv2;
    assign o_stall = !adv1;
    assign o_valid = r_v3;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_valid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1 && i_valid) begin
            r_action <= i_action;
            r_a      <= i_operand_a;
            r_b      <= i_operand_b;
            r_imm    <= i_immediate;
            r_dw     <= i_dest_width;
        end
    end

    vmia_logic u_logic (
        .i_action     (r_action),
        .i_operand_a  (r_a),
        .i_operand_b  (r_b),
        .i_immediate  (r_imm),
        .i_dest_width (r_dw),
        .o_result     (n_other)
    );

    // immediate multiply shares the low-by-low multiplier
    always_comb begin
        n_ctl.is_mul64   = (vmia_pkg::t_action'(r_action) == vmia_pkg::ACT_MUL64);
        n_ctl.is_mul32   = (vmia_pkg::t_action'(r_action) == vmia_pkg::ACT_MUL32) ||
                           (vmia_pkg::t_action'(r_action) == vmia_pkg::ACT_MUL32I);
        n_ctl.dest_width = r_dw;
        mul_b_lo = (vmia_pkg::t_action'(r_action) == vmia_pkg::ACT_MUL32I)
                   ? vmia_pkg::sext_imm(r_imm) : r_b[31:0];
    end

    // cross terms only need their low word
    assign n_p_ll = {32'd0, r_a[31:0]}  * {32'd0, mul_b_lo};
    assign n_p_lh = r_a[31:0]  * r_b[63:32];
    assign n_p_hl = r_a[63:32] * r_b[31:0];

    always_ff @(posedge i_clk) begin
        if (adv2 && r_v1) begin
            r_p_ll  <= n_p_ll;
            r_p_lh  <= n_p_lh;
            r_p_hl  <= n_p_hl;
            r_other <= n_other;
            r_ctl   <= n_ctl;
        end
    end

    // low 64 bits of the full product: cross terms only touch the upper word
    assign cross_sum = r_p_lh + r_p_hl;

    always_comb begin
        if (r_ctl.is_mul64) begin
            n_result = r_p_ll + {cross_sum, 32'd0};
        end else if (r_ctl.is_mul32) begin
            n_result = vmia_pkg::width_mask(r_p_ll[31:0], r_ctl.dest_width);
        end else begin
            n_result = r_other;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv3 && r_v2) begin
            r_result <= n_result;
        end
    end

endmodule

`default_nettype wire

// File: rtl/vmia_logic.sv
// non-multiply operations of the vm integer alu: add, sub, negate, logical not,
// compare, extend and truncate; depends on vmia_pkg
`default_nettype none

module vmia_logic (
    input  wire logic [4:0]  i_action,
    input  wire logic [63:0] i_operand_a,
    input  wire logic [63:0] i_operand_b,
    input  wire logic [7:0]  i_immediate,
    input  wire logic [1:0]  i_dest_width,
    output logic      [63:0] o_result
);

    logic [31:0] a32;
    logic [31:0] b32;
    logic [31:0] imm32;

    assign a32   = i_operand_a[31:0];
    assign b32   = i_operand_b[31:0];
    assign imm32 = vmia_pkg::sext_imm(i_immediate);

    always_comb begin
        o_result = 64'd0;
        case (vmia_pkg::t_action'(i_action))
            vmia_pkg::ACT_NEG32:
                o_result = vmia_pkg::width_mask(32'd0 - a32, i_dest_width);
            vmia_pkg::ACT_NEG64:  o_result = 64'd0 - i_operand_a;
            vmia_pkg::ACT_NOT:    o_result = {63'd0, a32 == 32'd0};
            vmia_pkg::ACT_ADD32:
                o_result = vmia_pkg::width_mask(a32 + b32, i_dest_width);
            vmia_pkg::ACT_SUB32:
                o_result = vmia_pkg::width_mask(a32 - b32, i_dest_width);
            vmia_pkg::ACT_ADD32I:
                o_result = vmia_pkg::width_mask(a32 + imm32, i_dest_width);
            vmia_pkg::ACT_SUB32I:
                o_result = vmia_pkg::width_mask(a32 - imm32, i_dest_width);
            vmia_pkg::ACT_ADD64:  o_result = i_operand_a + i_operand_b;
            vmia_pkg::ACT_SUB64:  o_result = i_operand_a - i_operand_b;
            vmia_pkg::ACT_EQ32:   o_result = {63'd0, a32 == b32};
            vmia_pkg::ACT_LT32:   o_result = {63'd0, $signed(a32) < $signed(b32)};
            vmia_pkg::ACT_EQ32I:  o_result = {63'd0, a32 == imm32};
            vmia_pkg::ACT_LT32I:  o_result = {63'd0, $signed(a32) < $signed(imm32)};
            vmia_pkg::ACT_EQ64:   o_result = {63'd0, i_operand_a == i_operand_b};
            vmia_pkg::ACT_LT64:
                o_result = {63'd0, $signed(i_operand_a) < $signed(i_operand_b)};
            vmia_pkg::ACT_SEXT32: o_result = {{32{a32[31]}}, a32};
            vmia_pkg::ACT_SEXT8:  o_result = {32'd0, {24{a32[7]}}, a32[7:0]};
            vmia_pkg::ACT_TRUNC8: o_result = {56'd0, a32[7:0]};
            vmia_pkg::ACT_TRUNC16: o_result = {48'd0, a32[15:0]};
            vmia_pkg::ACT_TRUNC32: o_result = {32'd0, a32};
            // multiplies are resolved in the top level, unused codes give zero
            default:              o_result = 64'd0;
        endcase
    end

endmodule

`default_nettype wire

// File: tb/tb_vm_integer_alu_unit.sv
// self-checking testbench for vm_integer_alu_unit: directed table, then random beats
// depends on vmia_pkg and the vm_integer_alu_unit rtl
`default_nettype none

module tb_vm_integer_alu_unit;

    // timing and run shape
    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 4;
    localparam int MAX_GAP        = 5;
    localparam int RANDOM_BEATS   = 600;
    localparam int LONG_HOLD      = 64;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int NUM_DIRECTED   = 25;

    // opcodes the unit does not decode, they must give zero
    localparam logic [4:0] ACT_UNUSED_LO = 5'd23;
    localparam logic [4:0] ACT_UNUSED_HI = 5'd31;

    // one row of the directed table; want is only used when has_want is set
    typedef struct packed {
        logic [4:0]  action;
        logic [63:0] a;
        logic [63:0] b;
        logic [7:0]  imm;
        logic [1:0]  dw;
        logic        has_want;
        logic [63:0] want;
    } t_vector;

    // an outstanding result, with its opcode for the report
    typedef struct packed {
        logic [4:0]  action;
        logic [63:0] value;
    } t_pending;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [4:0]  i_action;
    logic [63:0] i_operand_a;
    logic [63:0] i_operand_b;
    logic [7:0]  i_immediate;
    logic [1:0]  i_dest_width;
    logic        o_valid;
    logic        i_stall;
    logic [63:0] o_result;

    vm_integer_alu_unit DUT (.*);

    // results still owed by the unit, oldest first
    t_pending pending_results[$];

    // run bookkeeping
    int   beats_in;
    int   results_checked;
    int   mismatches;
    int   input_stall_cycles;
    bit   action_seen [32];
    bit   idle_on;
    logic hold_off_toggle;

    // extremes, every opcode, an unused code and the alternate width code;
    // the last row is left to the predictor
    t_vector directed_vectors [NUM_DIRECTED] = '{
        '{vmia_pkg::ACT_NEG32, 64'h1, 64'h0, 8'h00, vmia_pkg::DW_32,
          1'b1, 64'h0000_0000_FFFF_FFFF},
        '{vmia_pkg::ACT_NEG64, 64'h1, 64'h0, 8'h00, vmia_pkg::DW_32,
          1'b1, 64'hFFFF_FFFF_FFFF_FFFF},
        '{vmia_pkg::ACT_NOT, 64'hFFFF_FFFF_0000_0000, 64'h0, 8'h00, vmia_pkg::DW_32,
          1'b1, 64'h1},
        '{vmia_pkg::ACT_ADD32, 64'hFFFF_FFFF, 64'h1, 8'h00, vmia_pkg::DW_32,
          1'b1, 64'h0},
        '{vmia_pkg::ACT_SUB32, 64'h0, 64'h1, 8'h00, vmia_pkg::DW_16,
          1'b1, 64'h0000_0000_0000_FFFF},
        '{vmia_pkg::ACT_MUL32, 64'hFFFF_FFFF, 64'hFFFF_FFFF, 8'h00, vmia_pkg::DW_8,
          1'b1, 64'h1},
        '{vmia_pkg::ACT_ADD32I, 64'h7FFF_FFFF, 64'h0, 8'h01, vmia_pkg::DW_ALT,
          1'b1, 64'h0000_0000_8000_0000},
        '{vmia_pkg::ACT_SUB32I, 64'h0, 64'h0, 8'h80, vmia_pkg::DW_32,
          1'b1, 64'h80},
        '{vmia_pkg::ACT_MUL32I, 64'h2, 64'h0, 8'hFF, vmia_pkg::DW_32,
          1'b1, 64'h0000_0000_FFFF_FFFE},
        '{vmia_pkg::ACT_ADD64, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1, 8'h00, vmia_pkg::DW_32,
          1'b1, 64'h0},
        '{vmia_pkg::ACT_SUB64, 64'h0, 64'h1, 8'h00, vmia_pkg::DW_32,
          1'b1, 64'hFFFF_FFFF_FFFF_FFFF},
        '{vmia_pkg::ACT_MUL64, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00,
          vmia_pkg::DW_32, 1'b1, 64'h1},
        '{vmia_pkg::ACT_EQ32, 64'h1_0000_0005, 64'h2_0000_0005, 8'h00, vmia_pkg::DW_32,
          1'b1, 64'h1},
        '{vmia_pkg::ACT_LT32, 64'h8000_0000, 64'h7FFF_FFFF, 8'h00, vmia_pkg::DW_32,
          1'b1, 64'h1},
        '{vmia_pkg::ACT_EQ32I, 64'hFFFF_FF80, 64'h0, 8'h80, vmia_pkg::DW_32,
          1'b1, 64'h1},
        '{vmia_pkg::ACT_LT32I, 64'h7F, 64'h0, 8'h7F, vmia_pkg::DW_32,
          1'b1, 64'h0},
        '{vmia_pkg::ACT_EQ64, 64'h1_0000_0005, 64'h2_0000_0005, 8'h00, vmia_pkg::DW_32,
          1'b1, 64'h0},
        '{vmia_pkg::ACT_LT64, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 8'h00,
          vmia_pkg::DW_32, 1'b1, 64'h1},
        '{vmia_pkg::ACT_SEXT32, 64'h8000_0000, 64'h0, 8'h00, vmia_pkg::DW_32,
          1'b1, 64'hFFFF_FFFF_8000_0000},
        '{vmia_pkg::ACT_SEXT8, 64'h80, 64'h0, 8'h00, vmia_pkg::DW_32,
          1'b1, 64'h0000_0000_FFFF_FF80},
        '{vmia_pkg::ACT_TRUNC8, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 8'h00, vmia_pkg::DW_32,
          1'b1, 64'hFF},
        '{vmia_pkg::ACT_TRUNC16, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 8'h00, vmia_pkg::DW_32,
          1'b1, 64'hFFFF},
        '{vmia_pkg::ACT_TRUNC32, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 8'h00, vmia_pkg::DW_32,
          1'b1, 64'hFFFF_FFFF},
        '{ACT_UNUSED_HI, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF,
          vmia_pkg::DW_ALT, 1'b1, 64'h0},
        '{vmia_pkg::ACT_MUL64, 64'h1234_5678_9ABC_DEF0, 64'h0FED_CBA9_8765_4321, 8'h00,
          vmia_pkg::DW_32, 1'b0, 64'h0}
    };

    // what the unit should write back for one instruction
    function automatic logic [63:0] alu_result(
        input logic [4:0]  act,
        input logic [63:0] a64,
        input logic [63:0] b64,
        input logic [7:0]  imm8,
        input logic [1:0]  dw
    );
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] imm;
        logic [31:0] word;
        logic [63:0] r;
        logic        narrow;
        a      = a64[31:0];
        b      = b64[31:0];
        imm    = {{24{imm8[7]}}, imm8};
        word   = '0;
        r      = '0;
        narrow = 1'b1;
        // 32-bit ops that go through the destination-width mask
        case (act)
            vmia_pkg::ACT_NEG32:  word = 32'd0 - a;
            vmia_pkg::ACT_ADD32:  word = a + b;
            vmia_pkg::ACT_SUB32:  word = a - b;
            vmia_pkg::ACT_MUL32:  word = a * b;
            vmia_pkg::ACT_ADD32I: word = a + imm;
            vmia_pkg::ACT_SUB32I: word = a - imm;
            vmia_pkg::ACT_MUL32I: word = a * imm;
            default:              narrow = 1'b0;
        endcase
        if (narrow) begin
            case (dw)
                vmia_pkg::DW_16: r = {48'h0, word[15:0]};
                vmia_pkg::DW_8:  r = {56'h0, word[7:0]};
                default:         r = {32'h0, word};
            endcase
        end else begin
            case (act)
                vmia_pkg::ACT_NEG64:   r = 64'd0 - a64;
                vmia_pkg::ACT_NOT:     r = (a == 32'd0) ? 64'd1 : 64'd0;
                vmia_pkg::ACT_ADD64:   r = a64 + b64;
                vmia_pkg::ACT_SUB64:   r = a64 - b64;
                vmia_pkg::ACT_MUL64:   r = a64 * b64;
                vmia_pkg::ACT_EQ32:    r = (a == b) ? 64'd1 : 64'd0;
                vmia_pkg::ACT_LT32:    r = ($signed(a) < $signed(b)) ? 64'd1 : 64'd0;
                vmia_pkg::ACT_EQ32I:   r = (a == imm) ? 64'd1 : 64'd0;
                vmia_pkg::ACT_LT32I:   r = ($signed(a) < $signed(imm)) ? 64'd1 : 64'd0;
                vmia_pkg::ACT_EQ64:    r = (a64 == b64) ? 64'd1 : 64'd0;
                vmia_pkg::ACT_LT64:    r = ($signed(a64) < $signed(b64)) ? 64'd1 : 64'd0;
                vmia_pkg::ACT_SEXT32:  r = {{32{a[31]}}, a};
                // low byte widened to 32 bits only, upper word stays zero
                vmia_pkg::ACT_SEXT8:   r = {32'h0, {24{a[7]}}, a[7:0]};
                vmia_pkg::ACT_TRUNC8:  r = {56'h0, a[7:0]};
                vmia_pkg::ACT_TRUNC16: r = {48'h0, a[15:0]};
                vmia_pkg::ACT_TRUNC32: r = {32'h0, a};
                default:               r = 64'd0;
            endcase
        end
        return r;
    endfunction

    // operand values biased toward the edges of signed and unsigned ranges
    function automatic logic [63:0] pick_operand();
        logic [63:0] v;
        case ($urandom_range(0, 9))
            0:       v = 64'h0;
            1:       v = 64'h1;
            2:       v = 64'hFFFF_FFFF_FFFF_FFFF;
            3:       v = 64'h8000_0000_0000_0000;
            4:       v = 64'h7FFF_FFFF_FFFF_FFFF;
            5:       v = {$urandom(), 32'h8000_0000};
            6:       v = {$urandom(), 32'h7FFF_FFFF};
            7:       v = {32'h0, $urandom()};
            default: v = {$urandom(), $urandom()};
        endcase
        return v;
    endfunction

    // clock
    initial i_clk = 1'b0;
    always #CLK_HALF i_clk = ~i_clk;

    // present one beat, after a random gap while idle_on is set, and hold it until taken,
    // then queue what the unit owes for it
    task automatic offer_beat(
        input logic [4:0]  act,
        input logic [63:0] a,
        input logic [63:0] b,
        input logic [7:0]  imm,
        input logic [1:0]  dw,
        input logic [63:0] want
    );
        int gap;
        gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_action     <= act;
        i_operand_a  <= a;
        i_operand_b  <= b;
        i_immediate  <= imm;
        i_dest_width <= dw;
        do @(posedge i_clk); while (o_stall);
        pending_results.push_back(t_pending'{act, want});
        action_seen[act] = 1'b1;
        beats_in++;
    endtask

    // compare one taken result with the oldest outstanding one
    task automatic check_result(input logic [63:0] got);
        t_pending exp;
        if (pending_results.size() == 0) begin
            $error("result beat with nothing outstanding: result %h", got);
            mismatches++;
        end else begin
            exp = pending_results.pop_front();
            results_checked++;
            if (got !== exp.value) begin
                $error("result mismatch (action %0d): expected %h, actual %h",
                       exp.action, exp.value, got);
                mismatches++;
            end
        end
    endtask

    // result side: checks every taken beat and drives i_stall; a short random
    // pause after each beat while idle_on is set, plus a long hold-off whenever the stimulus asks
    initial begin : result_side
        int   pause_left;
        int   hold_left;
        logic hold_seen;
        pause_left = 0;
        hold_left  = 0;
        hold_seen  = 1'b0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                check_result(o_result);
                pause_left = idle_on ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (hold_seen != hold_off_toggle) begin
                hold_seen = hold_off_toggle;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (pause_left > 0) begin
                pause_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // watchdog: a long run of cycles with no beat on either side means a hang
    always @(posedge i_clk) begin : watchdog
        int quiet;
        if (!i_rst_n) begin
            quiet = 0;
        end else begin
            if (i_valid && o_stall) input_stall_cycles++;
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("timeout: no beat for %0d cycles, %0d results outstanding",
                         quiet, pending_results.size());
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // stimulus and verdict
    initial begin : stimulus
        t_vector     row;
        logic [4:0]  act;
        logic [63:0] a;
        logic [63:0] b;
        logic [7:0]  imm;
        logic [1:0]  dw;
        int          codes_seen;

        beats_in           = 0;
        results_checked    = 0;
        mismatches         = 0;
        input_stall_cycles = 0;
        idle_on            = 1'b1;
        hold_off_toggle    = 1'b0;
        codes_seen         = 0;

        // every input known from time zero
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_action     <= '0;
        i_operand_a  <= '0;
        i_operand_b  <= '0;
        i_immediate  <= '0;
        i_dest_width <= '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table, typed results where obvious, predictor otherwise
        for (int i = 0; i < NUM_DIRECTED; i++) begin
            row = directed_vectors[i];
            offer_beat(row.action, row.a, row.b, row.imm, row.dw,
                       row.has_want ? row.want
                                    : alu_result(row.action, row.a, row.b, row.imm, row.dw));
        end

        // random part, with back-to-back stretches and one long receiver hold-off
        for (int i = 0; i < RANDOM_BEATS; i++) begin
            if (i == 150) idle_on = 1'b0;
            if (i == 200) hold_off_toggle = ~hold_off_toggle;
            if (i == 320) idle_on = 1'b1;
            if (i == 450) idle_on = 1'b0;
            if (i == 500) idle_on = 1'b1;

            if ($urandom_range(0, 15) == 0) begin
                act = 5'($urandom_range(int'(ACT_UNUSED_LO), int'(ACT_UNUSED_HI)));
            end else begin
                act = 5'($urandom_range(0, int'(vmia_pkg::ACT_TRUNC32)));
            end
            a   = pick_operand();
            b   = pick_operand();
            imm = 8'($urandom());
            dw  = 2'($urandom_range(0, 3));
            // line up operands now and then so compares also come out true
            case ($urandom_range(0, 5))
                0:       b = a;
                1:       b[31:0] = a[31:0];
                2:       a[31:0] = {{24{imm[7]}}, imm};
                default: ;
            endcase
            offer_beat(act, a, b, imm, dw, alu_result(act, a, b, imm, dw));
        end
        i_valid <= 1'b0;

        // drain, then a few more cycles to catch any stray result
        wait (pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        for (int c = 0; c < 32; c++) codes_seen += action_seen[c];
        $display("run covered %0d input beats over %0d of 32 action codes, %0d results checked",
                 beats_in, codes_seen, results_checked);
        $display("input back-pressure seen on %0d cycles, %0d mismatches",
                 input_stall_cycles, mismatches);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
